// ===== sv/vector3_arithmetic_unit_core_defines.svh =====
// assertion macros for the vector3 arithmetic unit
// used by the top level; expects clk and rst_n in the including scope
`ifndef VECTOR3_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define VAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define VAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VAU_ASSERT_IMPL(lbl, ante, cons, msg)
`define VAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/vau_pkg.sv =====
// shared types, codes and saturation helper for the vector3 arithmetic unit
// no dependencies
`default_nettype none
package vau_pkg;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int WORD_W = 32;
  localparam int PROD_W = 66;
  localparam int WIDE_W = 68;
  localparam int ROOT_STEPS = 32;
  localparam logic [15:0] THRESHOLD_RST = 16'd1;
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic signed [WIDE_W-1:0] S32_MAX_W = 68'sd2147483647;
  localparam logic signed [WIDE_W-1:0] S32_MIN_W = -68'sd2147483648;

  typedef enum logic [3:0] {
    ACT_ADD       = 4'd0,
    ACT_SUB       = 4'd1,
    ACT_SCALE     = 4'd2,
    ACT_DIVIDE    = 4'd3,
    ACT_DOT       = 4'd4,
    ACT_CROSS     = 4'd5,
    ACT_MAG       = 4'd6,
    ACT_SQRMAG    = 4'd7,
    ACT_DISTANCE  = 4'd8,
    ACT_NORMALIZE = 4'd9,
    ACT_LERP      = 4'd10,
    ACT_EQUAL     = 4'd11
  } action_t;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scalar_in;
  } vau_in_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               vectors_equal;
    logic               divide_by_zero;
  } vau_out_t;

  typedef struct packed {
    logic [3:0]       action;
    logic             eq;
    logic [2:0][31:0] vec;
    logic [31:0]      sc;
    logic [2:0][31:0] a;
    logic [31:0]      s;
  } side_t;

  typedef struct packed {
    side_t      side;
    logic [2:0] neg;
    logic       nzero;
  } div_side_t;

  function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [31:0] r;
    if (v > S32_MAX_W) begin
      r = S32_MAX;
    end else if (v < S32_MIN_W) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/vau_front.sv =====
// operand select, shared multipliers and product combine (three stages)
// depends on vau_pkg
`default_nettype none
module vau_front #(
  parameter int FRACTION_BITS = vau_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  vau_pkg::vau_in_t in_req,
  output logic            out_v,
  output logic [63:0]     out_rad,
  output vau_pkg::side_t  out_side
);
  import vau_pkg::*;

  localparam logic signed [32:0] ONE_Q = 33'sd1 <<< FRACTION_BITS;

  logic signed [32:0] a_w [3];
  logic signed [32:0] b_w [3];
  logic signed [32:0] s_w;
  logic signed [32:0] tc;
  logic signed [32:0] diff [3];
  logic signed [32:0] sum_ab [3];
  logic signed [32:0] d_w [3];
  logic [31:0]        dsat [3];
  logic signed [32:0] ma_nxt [6];
  logic signed [32:0] mb_nxt [6];
  logic signed [32:0] ma_r [6];
  logic signed [32:0] mb_r [6];
  logic signed [PROD_W-1:0] p_r [6];
  logic signed [WIDE_W-1:0] pw [6];
  logic signed [WIDE_W-1:0] sum3;
  logic signed [WIDE_W-1:0] aw [3];
  side_t side_nxt, side1_r, side2_r, side3_nxt, side3_r;
  logic  v1_r, v2_r, v3_r;
  logic [63:0] rad_r;

  // stage 1: operand select
  always_comb begin
    a_w[0] = {in_req.ax[31], in_req.ax};
    a_w[1] = {in_req.ay[31], in_req.ay};
    a_w[2] = {in_req.az[31], in_req.az};
    b_w[0] = {in_req.bx[31], in_req.bx};
    b_w[1] = {in_req.by[31], in_req.by};
    b_w[2] = {in_req.bz[31], in_req.bz};
    s_w    = {in_req.scalar_in[31], in_req.scalar_in};
    if (s_w < 33'sd0) begin
      tc = '0;
    end else if (s_w > ONE_Q) begin
      tc = ONE_Q;
    end else begin
      tc = s_w;
    end
    side_nxt.action = in_req.action;
    side_nxt.eq = (in_req.ax == in_req.bx) && (in_req.ay == in_req.by) &&
                  (in_req.az == in_req.bz);
    side_nxt.vec = '0;
    side_nxt.sc = '0;
    side_nxt.a[0] = in_req.ax;
    side_nxt.a[1] = in_req.ay;
    side_nxt.a[2] = in_req.az;
    side_nxt.s = in_req.scalar_in;
    for (int i = 0; i < 3; i++) begin
      diff[i] = b_w[i] - a_w[i];
      sum_ab[i] = a_w[i] + b_w[i];
      dsat[i] = sat32({{(WIDE_W-33){diff[i][32]}}, diff[i]});
      d_w[i] = {dsat[i][31], dsat[i]};
    end
    for (int i = 0; i < 6; i++) begin
      ma_nxt[i] = '0;
      mb_nxt[i] = '0;
    end
    case (in_req.action)
      ACT_ADD: begin
        for (int i = 0; i < 3; i++) begin
          side_nxt.vec[i] = sat32({{(WIDE_W-33){sum_ab[i][32]}}, sum_ab[i]});
        end
      end
      ACT_SUB: begin
        for (int i = 0; i < 3; i++) begin
          side_nxt.vec[i] = sat32(-WIDE_W'(diff[i]));
        end
      end
      ACT_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = a_w[i];
          mb_nxt[i] = s_w;
        end
      end
      ACT_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = a_w[i];
          mb_nxt[i] = b_w[i];
        end
      end
      ACT_CROSS: begin
        ma_nxt[0] = a_w[1]; mb_nxt[0] = b_w[2];
        ma_nxt[3] = a_w[2]; mb_nxt[3] = b_w[1];
        ma_nxt[1] = a_w[2]; mb_nxt[1] = b_w[0];
        ma_nxt[4] = a_w[0]; mb_nxt[4] = b_w[2];
        ma_nxt[2] = a_w[0]; mb_nxt[2] = b_w[1];
        ma_nxt[5] = a_w[1]; mb_nxt[5] = b_w[0];
      end
      ACT_MAG, ACT_SQRMAG, ACT_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = a_w[i];
          mb_nxt[i] = a_w[i];
        end
      end
      ACT_DISTANCE: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = d_w[i];
          mb_nxt[i] = d_w[i];
        end
      end
      ACT_LERP: begin
        for (int i = 0; i < 3; i++) begin
          ma_nxt[i] = diff[i];
          mb_nxt[i] = tc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= side_nxt;
    side2_r <= side1_r;
    side3_r <= side3_nxt;
    rad_r   <= sum3[63:0];
    for (int i = 0; i < 6; i++) begin
      ma_r[i] <= ma_nxt[i];
      mb_r[i] <= mb_nxt[i];
      p_r[i]  <= ma_r[i] * mb_r[i];
    end
  end

  // stage 3: fold products into results
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pw[i] = {{(WIDE_W-PROD_W){p_r[i][PROD_W-1]}}, p_r[i]};
    end
    for (int i = 0; i < 3; i++) begin
      aw[i] = $signed({{(WIDE_W-32){side2_r.a[i][31]}}, side2_r.a[i]});
    end
    sum3 = pw[0] + pw[1] + pw[2];
    side3_nxt = side2_r;
    case (side2_r.action)
      ACT_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          side3_nxt.vec[i] = sat32(pw[i] >>> FRACTION_BITS);
        end
      end
      ACT_DOT, ACT_SQRMAG: begin
        side3_nxt.sc = sat32(sum3 >>> FRACTION_BITS);
      end
      ACT_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          side3_nxt.vec[i] = sat32((pw[i] - pw[i+3]) >>> FRACTION_BITS);
        end
      end
      ACT_LERP: begin
        for (int i = 0; i < 3; i++) begin
          side3_nxt.vec[i] = sat32(aw[i] + (pw[i] >>> FRACTION_BITS));
        end
      end
      default: begin
      end
    endcase
  end

  assign out_v    = v3_r;
  assign out_rad  = rad_r;
  assign out_side = side3_r;
endmodule
`default_nettype wire

// ===== sv/vau_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on vau_pkg
`default_nettype none
module vau_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_v,
  input  logic [63:0]    in_rad,
  input  vau_pkg::side_t in_side,
  output logic           out_v,
  output logic [31:0]    out_root,
  output vau_pkg::side_t out_side
);
  import vau_pkg::*;

  logic        v_r    [ROOT_STEPS];
  logic [63:0] n_r    [ROOT_STEPS];
  logic [63:0] res_r  [ROOT_STEPS];
  side_t       side_r [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT_C = 64'd1 << (62 - 2 * k);
    logic        v_in;
    logic [63:0] n_in, res_in, trial, n_nxt, res_nxt;
    side_t       side_in;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign n_in    = in_rad;
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[k-1];
      assign n_in    = n_r[k-1];
      assign res_in  = res_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      trial = res_in + BIT_C;
      if (n_in >= trial) begin
        n_nxt   = n_in - trial;
        res_nxt = (res_in >> 1) + BIT_C;
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      n_r[k]    <= n_nxt;
      res_r[k]  <= res_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_v    = v_r[ROOT_STEPS-1];
  assign out_root = res_r[ROOT_STEPS-1][31:0];
  assign out_side = side_r[ROOT_STEPS-1];
endmodule
`default_nettype wire

// ===== sv/vau_div.sv =====
// three-lane pipelined restoring divider, one quotient bit per stage
// depends on vau_pkg
`default_nettype none
module vau_div #(
  parameter int FRACTION_BITS = vau_pkg::FRACTION_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_v,
  input  logic [2:0][vau_pkg::WORD_W+FRACTION_BITS-1:0]    in_num,
  input  logic [31:0]                                      in_den,
  input  vau_pkg::div_side_t                               in_side,
  output logic                                             out_v,
  output logic [2:0][vau_pkg::WORD_W+FRACTION_BITS-1:0]    out_q,
  output vau_pkg::div_side_t                               out_side
);
  import vau_pkg::*;

  localparam int NW = WORD_W + FRACTION_BITS;

  logic                 v_r    [NW];
  logic [2:0][31:0]     rem_r  [NW];
  logic [2:0][NW-1:0]   w_r    [NW];
  logic [31:0]          den_r  [NW];
  div_side_t            side_r [NW];

  for (genvar j = 0; j < NW; j++) begin : g_step
    logic               v_in;
    logic [2:0][31:0]   rem_in, rem_nxt;
    logic [2:0][NW-1:0] w_in, w_nxt;
    logic [31:0]        den_in;
    div_side_t          side_in;
    logic [2:0][32:0]   trial, diff;
    logic [2:0]         ge;

    if (j == 0) begin : g_first
      assign v_in    = in_v;
      assign rem_in  = '0;
      assign w_in    = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_rest
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign w_in    = w_r[j-1];
      assign den_in  = den_r[j-1];
      assign side_in = side_r[j-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem_in[l], w_in[l][NW-1]};
        diff[l]  = trial[l] - {1'b0, den_in};
        ge[l]    = trial[l] >= {1'b0, den_in};
        rem_nxt[l] = ge[l] ? diff[l][31:0] : trial[l][31:0];
        w_nxt[l]   = {w_in[l][NW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      w_r[j]    <= w_nxt;
      den_r[j]  <= den_in;
      side_r[j] <= side_in;
    end
  end

  assign out_v    = v_r[NW-1];
  assign out_q    = w_r[NW-1];
  assign out_side = side_r[NW-1];
endmodule
`default_nettype wire

// ===== sv/vector3_arithmetic_unit_core.sv =====
// top level of the vector3 arithmetic unit: request port, threshold register, pipeline
// depends on vau_pkg, vau_front, vau_sqrt, vau_div and the defines header
//
// Fully pipelined: a request is taken in every cycle while busy is low, and every request
// passes through every stage below, whatever the operation; its result appears on
// out_strobe for a single cycle; the receiver cannot stall it, so nothing is ever held
// back. The pipeline is made of the square root pipeline (32 steps) and the divider
// (32 + FRACTION_BITS quotient bits), plus three front stages, one divider setup stage
// and the output register. busy is high only while in reset and the cycle after.
`default_nettype none
`include "vector3_arithmetic_unit_core_defines.svh"
module vector3_arithmetic_unit_core #(
  parameter int FRACTION_BITS = vau_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  vau_pkg::vau_in_t  in_req,
  output logic              out_strobe,
  output vau_pkg::vau_out_t out_res,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import vau_pkg::*;

  localparam int NW = WORD_W + FRACTION_BITS;

  logic        busy_r;
  logic [15:0] thr_r;
  logic        in_fire;

  logic        fr_v;
  logic [63:0] fr_rad;
  side_t       fr_side;

  logic        sq_v;
  logic [31:0] sq_root;
  side_t       sq_side;

  logic               is_div;
  logic [31:0]        s_abs;
  logic [31:0]        a_abs [3];
  logic [2:0][NW-1:0] num_nxt, num_r;
  logic [31:0]        den_nxt, den_r;
  div_side_t          ds_nxt, ds_r;
  logic               pv_r;

  logic               dv;
  logic [2:0][NW-1:0] dq;
  div_side_t          dside;

  logic signed [WIDE_W-1:0] qw [3];
  logic [31:0]              qsat [3];
  logic [2:0][31:0]         vec;
  logic                     dz;
  vau_out_t                 res_nxt, res_r;
  logic                     strobe_r;

  assign in_fire = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      thr_r  <= THRESHOLD_RST;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  vau_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (in_fire),
    .in_req   (in_req),
    .out_v    (fr_v),
    .out_rad  (fr_rad),
    .out_side (fr_side)
  );

  vau_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (fr_v),
    .in_rad   (fr_rad),
    .in_side  (fr_side),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // divider setup
  always_comb begin
    is_div  = sq_side.action == ACT_DIVIDE;
    s_abs   = sq_side.s[31] ? (~sq_side.s + 32'd1) : sq_side.s;
    den_nxt = is_div ? s_abs : sq_root;
    ds_nxt.side  = sq_side;
    ds_nxt.nzero = !(sq_root > {16'd0, thr_r});
    for (int i = 0; i < 3; i++) begin
      a_abs[i] = sq_side.a[i][31] ? (~sq_side.a[i] + 32'd1) : sq_side.a[i];
      num_nxt[i] = {a_abs[i], {FRACTION_BITS{1'b0}}};
      ds_nxt.neg[i] = sq_side.a[i][31] ^ (is_div & sq_side.s[31]);
    end
    if (sq_side.action == ACT_MAG || sq_side.action == ACT_DISTANCE) begin
      ds_nxt.side.sc = sq_root[31] ? S32_MAX : sq_root;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    ds_r  <= ds_nxt;
  end

  vau_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (pv_r),
    .in_num   (num_r),
    .in_den   (den_r),
    .in_side  (ds_r),
    .out_v    (dv),
    .out_q    (dq),
    .out_side (dside)
  );

  // result select and saturation
  always_comb begin
    dz = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qw[i] = WIDE_W'(dq[i]);
      qsat[i] = sat32(dside.neg[i] ? -qw[i] : qw[i]);
    end
    case (dside.side.action)
      ACT_DIVIDE: begin
        if (dside.side.s == '0) begin
          dz = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (dside.side.a[i][31]) begin
              vec[i] = S32_MIN;
            end else if (dside.side.a[i] != '0) begin
              vec[i] = S32_MAX;
            end else begin
              vec[i] = '0;
            end
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            vec[i] = qsat[i];
          end
        end
      end
      ACT_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          vec[i] = dside.nzero ? '0 : qsat[i];
        end
      end
      default: begin
        vec = dside.side.vec;
      end
    endcase
    res_nxt.rx             = vec[0];
    res_nxt.ry             = vec[1];
    res_nxt.rz             = vec[2];
    res_nxt.scalar_out     = dside.side.sc;
    res_nxt.vectors_equal  = dside.side.eq;
    res_nxt.divide_by_zero = dz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  `VAU_ASSERT_NEXT(a_busy_release, 1'b1, !busy, "busy high after reset")
  `VAU_ASSERT_IMPL(a_dz_scalar, out_strobe && out_res.divide_by_zero, out_res.scalar_out == '0, "divide by zero with nonzero scalar")
  `VAU_ASSERT_IMPL(a_vec_scalar, out_strobe && (out_res.rx != '0 || out_res.ry != '0 || out_res.rz != '0), out_res.scalar_out == '0, "vector and scalar result both set")
endmodule
`default_nettype wire

// ===== sim/tb_vector3_arithmetic_unit_core.sv =====
// testbench for vector3_arithmetic_unit_core: random and directed vector requests
// checked against a behavioral predictor; depends on vau_pkg and the core rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_vector3_arithmetic_unit_core;
  import vau_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 69 + FB;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  vau_in_t in_req = '0;
  logic out_strobe;
  vau_out_t out_res;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  vector3_arithmetic_unit_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  vau_in_t pending_reqs[$];
  vau_out_t expected_results[$];
  logic [15:0] threshold = THRESHOLD_RST;
  int errors = 0;
  int watchdog = 0;
  bit stim_done = 0;
  int burst_left = 0;
  int gap_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_frac(input longint p);
    return p >>> FB;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] sum_sq(input longint x, input longint y, input longint z);
    logic [63:0] mx, my, mz;
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    mz = z < 0 ? -z : z;
    return mx * mx + my * my + mz * mz;
  endfunction

  function automatic longint mag_clip(input longint x, input longint y, input longint z);
    logic [63:0] m;
    m = root64(sum_sq(x, y, z));
    return m > 64'd2147483647 ? 64'sd2147483647 : longint'(m);
  endfunction

  // sums of two or three products may exceed 64 bits, so use 96-bit math
  function automatic longint fold_sum(input logic signed [95:0] s);
    logic signed [95:0] f;
    f = s >>> FB;
    if (f > 96'sd2147483647) return 64'sd2147483647;
    if (f < -96'sd2147483648) return -64'sd2147483648;
    return longint'(f);
  endfunction

  function automatic vau_out_t predict_result(input vau_in_t q);
    vau_out_t r;
    longint a[3], b[3], v[3], s, sc, tc;
    logic [63:0] m, sq;
    logic signed [95:0] acc;
    a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
    b[0] = q.bx; b[1] = q.by; b[2] = q.bz;
    s = q.scalar_in;
    v = '{0, 0, 0};
    sc = 0;
    r = '0;
    r.vectors_equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
    case (q.action)
      ACT_ADD: for (int i = 0; i < 3; i++) v[i] = clip32(a[i] + b[i]);
      ACT_SUB: for (int i = 0; i < 3; i++) v[i] = clip32(a[i] - b[i]);
      ACT_SCALE: for (int i = 0; i < 3; i++) v[i] = clip32(floor_frac(a[i] * s));
      ACT_DIVIDE: begin
        if (s == 0) begin
          r.divide_by_zero = 1'b1;
          for (int i = 0; i < 3; i++)
            v[i] = a[i] > 0 ? 64'sd2147483647 : (a[i] < 0 ? -64'sd2147483648 : 0);
        end else begin
          for (int i = 0; i < 3; i++) v[i] = clip32((a[i] <<< FB) / s);
        end
      end
      ACT_DOT: begin
        acc = 96'(a[0] * b[0]) + 96'(a[1] * b[1]) + 96'(a[2] * b[2]);
        sc = fold_sum(acc);
      end
      ACT_CROSS: begin
        v[0] = fold_sum(96'(a[1] * b[2]) - 96'(a[2] * b[1]));
        v[1] = fold_sum(96'(a[2] * b[0]) - 96'(a[0] * b[2]));
        v[2] = fold_sum(96'(a[0] * b[1]) - 96'(a[1] * b[0]));
      end
      ACT_MAG: sc = mag_clip(a[0], a[1], a[2]);
      ACT_SQRMAG: begin
        sq = sum_sq(a[0], a[1], a[2]) >> FB;
        sc = sq > 64'd2147483647 ? 64'sd2147483647 : longint'(sq);
      end
      ACT_DISTANCE: sc = mag_clip(clip32(b[0] - a[0]), clip32(b[1] - a[1]),
                                  clip32(b[2] - a[2]));
      ACT_NORMALIZE: begin
        m = root64(sum_sq(a[0], a[1], a[2]));
        if (m > threshold && m != 0)
          for (int i = 0; i < 3; i++) v[i] = clip32((a[i] <<< FB) / longint'(m));
      end
      ACT_LERP: begin
        tc = s < 0 ? 0 : (s > (64'sd1 <<< FB) ? (64'sd1 <<< FB) : s);
        for (int i = 0; i < 3; i++) v[i] = clip32(a[i] + floor_frac((b[i] - a[i]) * tc));
      end
      default: ;
    endcase
    r.rx = v[0][31:0];
    r.ry = v[1][31:0];
    r.rz = v[2][31:0];
    r.scalar_out = sc[31:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 32'd0;
      3, 4: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      5: return $urandom_range(0, 32'h0000_0100) - 32'h0000_0080;
      default: return $urandom;
    endcase
  endfunction

  function automatic vau_in_t random_req();
    vau_in_t q;
    q.action = $urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 11)) : 4'($urandom);
    q.ax = pick_word(); q.ay = pick_word(); q.az = pick_word();
    if ($urandom_range(0, 7) == 0) begin
      q.bx = q.ax; q.by = q.ay; q.bz = q.az;
    end else begin
      q.bx = pick_word(); q.by = pick_word(); q.bz = pick_word();
    end
    q.scalar_in = $urandom_range(0, 5) == 0 ? 32'd0 :
                  ($urandom_range(0, 2) == 0 ? 32'($urandom_range(0, 32'h0001_2000)) - 32'h1000
                                             : pick_word());
    return q;
  endfunction

  // driver: bursts of requests with random gaps
  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      void'(pending_reqs.pop_front());
    end
    if (!rst_n || pending_reqs.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else begin
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
      start <= 1'b1;
      in_req <= pending_reqs[0];
    end
  end

  // monitor
  always @(posedge clk) begin
    vau_out_t w;
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(predict_result(in_req));
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
          w = expected_results.pop_front();
          if (out_res.rx !== w.rx) report_mismatch("rx", out_res.rx, w.rx);
          if (out_res.ry !== w.ry) report_mismatch("ry", out_res.ry, w.ry);
          if (out_res.rz !== w.rz) report_mismatch("rz", out_res.rz, w.rz);
          if (out_res.scalar_out !== w.scalar_out)
            report_mismatch("scalar_out", out_res.scalar_out, w.scalar_out);
          if (out_res.vectors_equal !== w.vectors_equal)
            report_mismatch("vectors_equal", out_res.vectors_equal, w.vectors_equal);
          if (out_res.divide_by_zero !== w.divide_by_zero)
            report_mismatch("divide_by_zero", out_res.divide_by_zero, w.divide_by_zero);
        end
      end
      if ((start && !busy) || out_strobe || stim_done) watchdog <= 0;
      else if (pending_reqs.size() != 0 || expected_results.size() != 0)
        watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic drain();
    int n;
    n = 0;
    while ((pending_reqs.size() != 0 || start || expected_results.size() != 0)
           && n < 50 * WATCHDOG_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  task automatic queue_directed();
    vau_in_t q;
    for (int op = 0; op < 16; op++) begin
      q = '0;
      q.action = 4'(op);
      q.ax = S32_MAX; q.ay = S32_MIN; q.az = 32'h0001_8000;
      q.bx = S32_MIN; q.by = S32_MAX; q.bz = 32'hFFFF_0000;
      q.scalar_in = op == ACT_DIVIDE ? 32'd0 : S32_MIN;
      pending_reqs.push_back(q);
    end
    q = '0; q.action = ACT_DIVIDE; q.ax = 32'd5; q.ay = -32'sd5;
    pending_reqs.push_back(q);
    q = '0; q.action = ACT_NORMALIZE; q.ax = 32'd1;
    pending_reqs.push_back(q);
    q = '0; q.action = ACT_NORMALIZE; q.ax = 32'd3; q.ay = 32'd4;
    pending_reqs.push_back(q);
    q = '0; q.action = ACT_LERP; q.ax = 32'h0001_0000; q.bx = 32'h0003_0000;
    q.scalar_in = S32_MAX;
    pending_reqs.push_back(q);
    q.scalar_in = 32'h0000_8000;
    pending_reqs.push_back(q);
    q = '0; q.action = ACT_EQUAL; q.ax = -32'sd1; q.bx = -32'sd1;
    pending_reqs.push_back(q);
    q = '0; q.action = ACT_CROSS; q.ax = 32'h0001_0000; q.by = 32'h0001_0000;
    pending_reqs.push_back(q);
  endtask

  initial begin
    logic [15:0] levels[4];
    levels = '{16'd0, 16'hFFFF, 16'd200, 16'd5};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    queue_directed();
    drain();
    for (int p = 0; p < 4; p++) begin
      set_threshold(levels[p]);
      if (p == 0) queue_directed();
      for (int i = 0; i < 325; i++) pending_reqs.push_back(random_req());
      drain();
    end
    stim_done = 1;
    if (errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
